// ===== src/atms_pkg.sv =====
package atms_pkg;

  localparam int SAMPLE_BITS    = 12;
  localparam int COUNT_BITS     = 10;
  localparam int FAULT_LIMIT    = 10;
  localparam int FAULT_BITS     = 4;
  localparam int SUM_BITS       = SAMPLE_BITS + COUNT_BITS;
  localparam int STEP_BITS      = $clog2(SUM_BITS);
  localparam int TRIM_THRESHOLD = 2;
  localparam int COUNT_RESET    = 8;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_DATA_BITS  = 32;
  localparam int APB_ADDR_BITS  = 3;
  localparam int REG_IDX_BITS   = APB_ADDR_BITS - 2;
  localparam logic [REG_IDX_BITS-1:0] REG_SAMPLE_COUNT = '0;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_FAULT  = 2'd1,
    OP_ABORT  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_READY   = 3'd1,
    ST_FAILED  = 3'd2,
    ST_RESTART = 3'd3,
    ST_REINIT  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_t;

  typedef struct packed {
    op_t                    op;
    logic [SAMPLE_BITS-1:0] sample;
  } in_word_t;

  typedef struct packed {
    status_t                status;
    logic [SAMPLE_BITS-1:0] average;
  } out_word_t;

  // one queued result: status plus what the divider needs
  typedef struct packed {
    status_t                status;
    logic                   div;
    logic                   trim;
    logic [SUM_BITS-1:0]    sum;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [COUNT_BITS-1:0]  kept;
  } job_t;

endpackage

// ===== src/adc_trimmed_mean_sampler.sv =====
// Accepted words go through the queue to the registered result word; a due mean
// first passes the one-bit-per-cycle restoring divider in the back end.
// Non-mean events give one word per cycle unless res_stall or a mean in the divider
// holds them; new words are queued meanwhile until the queue is full (cmd_stall).
// Reset (rst, synchronous): session cleared, discard of next sample armed,
// sample_count back to 8, queue and output emptied.
module adc_trimmed_mean_sampler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  atms_pkg::in_word_t                  cmd,
  output logic                                res_valid,
  input  logic                                res_stall,
  output atms_pkg::out_word_t                 res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [atms_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [atms_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [atms_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import atms_pkg::*;

  logic [COUNT_BITS-1:0] sample_count;
  logic                  reg_hit;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  job_t                  push_job;
  job_t                  pop_job;

  assign pready    = 1'b1;
  assign reg_hit   = paddr[APB_ADDR_BITS-1:2] == REG_SAMPLE_COUNT;
  assign prdata    = reg_hit ? APB_DATA_BITS'(sample_count) : '0;
  assign cmd_stall = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= COUNT_BITS'(COUNT_RESET);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      sample_count <= pwdata[COUNT_BITS-1:0];
    end
  end

  atms_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .sample_count (sample_count),
    .q_full       (q_full),
    .push         (q_push),
    .job          (push_job)
  );

  atms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_job),
    .empty     (q_empty)
  );

  atms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (pop_job),
    .pop       (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("queue read while empty");

  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != ST_READY) |-> res.average == '0)
    else $error("nonzero average on non-result word");

  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |-> q_push) else $error("accepted word not queued");
`endif

endmodule

// ===== src/atms_front.sv =====
module atms_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  input  atms_pkg::in_word_t               cmd,
  input  logic [atms_pkg::COUNT_BITS-1:0]  sample_count,
  input  logic                             q_full,
  output logic                             push,
  output atms_pkg::job_t                   job
);
  import atms_pkg::*;

  logic                   discard_pending, discard_pending_next;
  logic [COUNT_BITS-1:0]  kept, kept_next;
  logic [SUM_BITS-1:0]    acc_sum, acc_sum_next;
  logic [SAMPLE_BITS-1:0] acc_min, acc_min_next;
  logic [SAMPLE_BITS-1:0] acc_max, acc_max_next;
  logic [FAULT_BITS-1:0]  fault_count, fault_count_next;
  logic                   reinit_done, reinit_done_next;

  logic [SUM_BITS-1:0]    sum_add;
  logic [SAMPLE_BITS-1:0] min_upd;
  logic [SAMPLE_BITS-1:0] max_upd;
  logic [COUNT_BITS-1:0]  kept_inc;
  logic [FAULT_BITS-1:0]  fault_inc;

  assign push      = cmd_valid && !q_full;
  assign sum_add   = acc_sum + SUM_BITS'(cmd.sample);
  assign min_upd   = (cmd.sample < acc_min) ? cmd.sample : acc_min;
  assign max_upd   = (cmd.sample > acc_max) ? cmd.sample : acc_max;
  assign kept_inc  = kept + COUNT_BITS'(1);
  assign fault_inc = fault_count + FAULT_BITS'(1);

  always_comb begin
    discard_pending_next = discard_pending;
    kept_next            = kept;
    acc_sum_next         = acc_sum;
    acc_min_next         = acc_min;
    acc_max_next         = acc_max;
    fault_count_next     = fault_count;
    reinit_done_next     = reinit_done;
    job                  = '0;
    job.status           = ST_BUSY;
    if (push) begin
      case (cmd.op)
        OP_SAMPLE: begin
          fault_count_next = '0;
          if (discard_pending) begin
            discard_pending_next = 1'b0;
          end else if (kept_inc >= sample_count) begin
            job.status           = ST_READY;
            job.div              = 1'b1;
            job.trim             = sample_count > COUNT_BITS'(TRIM_THRESHOLD);
            job.sum              = sum_add;
            job.lo               = min_upd;
            job.hi               = max_upd;
            job.kept             = kept_inc;
            kept_next            = '0;
            acc_sum_next         = '0;
            acc_min_next         = '1;
            acc_max_next         = '0;
            discard_pending_next = 1'b1;
            reinit_done_next     = 1'b0;
          end else begin
            acc_sum_next = sum_add;
            acc_min_next = min_upd;
            acc_max_next = max_upd;
            kept_next    = kept_inc;
          end
        end
        OP_FAULT: begin
          kept_next            = '0;
          acc_sum_next         = '0;
          acc_min_next         = '1;
          acc_max_next         = '0;
          discard_pending_next = 1'b1;
          if (fault_inc >= FAULT_BITS'(FAULT_LIMIT)) begin
            fault_count_next = '0;
            if (!reinit_done) begin
              reinit_done_next = 1'b1;
              job.status       = ST_REINIT;
            end else begin
              reinit_done_next = 1'b0;
              job.status       = ST_FAILED;
            end
          end else begin
            fault_count_next = fault_inc;
            job.status       = ST_RESTART;
          end
        end
        OP_ABORT: begin
          kept_next            = '0;
          acc_sum_next         = '0;
          acc_min_next         = '1;
          acc_max_next         = '0;
          discard_pending_next = 1'b1;
          fault_count_next     = '0;
          reinit_done_next     = 1'b0;
          job.status           = ST_FAILED;
        end
        default: begin
          // unused op code: no state change, busy word
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      discard_pending <= 1'b1;
      kept            <= '0;
      acc_sum         <= '0;
      acc_min         <= '1;
      acc_max         <= '0;
      fault_count     <= '0;
      reinit_done     <= 1'b0;
    end else begin
      discard_pending <= discard_pending_next;
      kept            <= kept_next;
      acc_sum         <= acc_sum_next;
      acc_min         <= acc_min_next;
      acc_max         <= acc_max_next;
      fault_count     <= fault_count_next;
      reinit_done     <= reinit_done_next;
    end
  end

endmodule

// ===== src/atms_queue.sv =====
module atms_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  atms_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output atms_pkg::job_t pop_data,
  output logic           empty
);
  import atms_pkg::*;

  job_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full     = count == QCNT_BITS'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

endmodule

// ===== src/atms_back.sv =====
module atms_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  atms_pkg::job_t      q_data,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_stall,
  output atms_pkg::out_word_t res
);
  import atms_pkg::*;

  back_state_t           state, state_next;
  logic [SUM_BITS-1:0]   dq;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dvs;
  logic [STEP_BITS-1:0]  step;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;
  logic                  out_free;
  logic                  load_div;
  logic                  load_direct;
  logic                  load_quot;

  assign out_free = !res_valid || !res_stall;
  assign trial    = {rem, dq[SUM_BITS-1]};
  assign fits     = trial >= {1'b0, dvs};

  always_comb begin
    state_next  = state;
    load_div    = 1'b0;
    load_direct = 1'b0;
    load_quot   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_data.div) begin
            load_div   = 1'b1;
            state_next = BK_DIV;
          end else if (out_free) begin
            load_direct = 1'b1;
          end
        end
      end
      BK_DIV: begin
        if (step == STEP_BITS'(SUM_BITS - 1)) begin
          state_next = BK_FIN;
        end
      end
      BK_FIN: begin
        if (out_free) begin
          load_quot  = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  assign pop = load_div || load_direct;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // restoring divider, one quotient bit per cycle; dq ends as the quotient
  always_ff @(posedge clk) begin
    if (load_div) begin
      rem  <= '0;
      step <= '0;
      if (q_data.trim) begin
        dq  <= q_data.sum - SUM_BITS'(q_data.lo) - SUM_BITS'(q_data.hi);
        dvs <= q_data.kept - COUNT_BITS'(TRIM_THRESHOLD);
      end else begin
        dq  <= q_data.sum;
        dvs <= q_data.kept;
      end
    end else if (state == BK_DIV) begin
      step <= step + STEP_BITS'(1);
      rem  <= fits ? COUNT_BITS'(trial - {1'b0, dvs}) : trial[COUNT_BITS-1:0];
      dq   <= {dq[SUM_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_direct || load_quot) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      res.status  <= q_data.status;
      res.average <= '0;
    end else if (load_quot) begin
      res.status  <= ST_READY;
      res.average <= dq[SAMPLE_BITS-1:0];
    end
  end

endmodule
